// File: src/ftnf_pkg.sv
// shared types, codes and helpers for the facing triangle nearest filter
// no dependencies; compiled first

package ftnf_pkg;

  localparam int IN_W   = 24;
  localparam int NORM_W = 16;
  localparam int THR_W  = 30;
  localparam int DOT_W  = 34;
  localparam int NEAR_W = 10;
  localparam int QIDX_W = 24;

  typedef logic [2:0]               mode_t;
  typedef logic signed [IN_W-1:0]   vec_t;
  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [THR_W-1:0]  thr_t;
  typedef logic [NEAR_W-1:0]        near_t;
  typedef logic [QIDX_W-1:0]        qidx_t;

  // word kinds on the input channel
  localparam mode_t MODE_TGT_CORNER = 3'd0;
  localparam mode_t MODE_TGT_NORMAL = 3'd1;
  localparam mode_t MODE_QRY_CORNER = 3'd2;
  localparam mode_t MODE_QRY_NORMAL = 3'd3;
  localparam mode_t MODE_CLEAR      = 3'd4;

  // -0.1 in Q2.28, rounded to nearest
  localparam thr_t THR_RESET = -30'sd26843546;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_CMP,
    S_NRD,
    S_DX,
    S_DY,
    S_DZ,
    S_DSUM,
    S_DONE
  } state_t;

  // clamp a 24 bit component to Q1.14 range
  function automatic norm_t sat16(input vec_t v);
    norm_t r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[NORM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/ftnf_in_if.sv
// input channel of the facing triangle nearest filter
// depends on ftnf_pkg

interface ftnf_in_if;
  import ftnf_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  vec_t  vec_x;
  vec_t  vec_y;
  vec_t  vec_z;

  modport source (output valid, output mode, output vec_x, output vec_y, output vec_z,
                  input ready);
  modport sink   (input valid, input mode, input vec_x, input vec_y, input vec_z,
                  output ready);
endinterface

// File: src/ftnf_out_if.sv
// result channel of the facing triangle nearest filter
// depends on ftnf_pkg

interface ftnf_out_if;
  import ftnf_pkg::*;

  logic  valid;
  logic  ready;
  logic  keep;
  near_t nearest_index;
  qidx_t query_index;
  logic  no_entries;

  modport source (output valid, output keep, output nearest_index, output query_index,
                  output no_entries, input ready);
  modport sink   (input valid, input keep, input nearest_index, input query_index,
                  input no_entries, output ready);
endinterface

// File: src/ftnf_table.sv
// target table memory: one write port, one registered read port
// no package dependencies

module ftnf_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 126,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/facing_triangle_nearest_filter_unit.sv
// top level of the facing triangle nearest filter
// depends on ftnf_pkg, ftnf_in_if, ftnf_out_if and ftnf_table

// Target triangles are loaded as corner words (summed into a pending corner
// accumulator) followed by a normal word that commits one table entry; query
// triangles arrive the same way, and the query normal word starts a search.
// The search reads the table in order through its single read port and feeds
// one shared multiplier, which squares the three centroid differences of each
// entry; the lowest index wins on equal distance. The same multiplier then
// forms the dot product of the query normal with the winner's normal, and the
// query is kept when it is below the threshold register. Corner, normal-commit
// and clear words leave the input side idle and ready. A query word keeps the
// input side busy through the search (three multiplies and one compare per
// entry, then a read of the winner's normal and the dot product); with an
// empty table it goes straight to the result. The finished word sits in an
// output register, so new input words are taken while it waits. The table
// needs no clearing after reset: only entries below the fill count are ever
// read. Commits past capacity are dropped.

module facing_triangle_nearest_filter_unit #(
  parameter int MAX_ENTRIES = 1024,
  parameter int COORD_BITS  = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  ftnf_in_if.sink          in_ch,
  ftnf_out_if.source       out_ch,
  input  logic             cfg_we,
  input  ftnf_pkg::thr_t   cfg_wdata
);
  import ftnf_pkg::*;

  localparam int SUM_W   = COORD_BITS + 2;
  localparam int DIFF_W  = SUM_W + 1;
  localparam int MUL_W   = (DIFF_W > NORM_W) ? DIFF_W : NORM_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIST_W  = 2 * DIFF_W;
  localparam int ENTRY_W = 3 * SUM_W + 3 * NORM_W;
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);

  // sequencer
  state_t state_r, state_nxt;

  // handshake decode
  logic in_acc;
  logic out_load;
  logic is_query;

  // fill count, pending corner sums, query counter, threshold
  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] pend_x_r, pend_y_r, pend_z_r;
  qidx_t                   qcnt_r;
  thr_t                    thr_r;

  // per-query working registers
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [DIST_W-1:0]       best_r;
  logic [DIST_W-1:0]       acc_r;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [PROD_W-1:0] prod_r;
  norm_t                   qn_x_r, qn_y_r, qn_z_r;
  qidx_t                   qidx_r;
  logic                    empty_r;
  logic                    keep_r;
  logic                    last_ent;

  // output register
  logic  out_valid_r;
  logic  out_keep_r;
  near_t out_near_r;
  qidx_t out_qidx_r;
  logic  out_empty_r;

  // table ports
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic signed [SUM_W-1:0]  rd_sx, rd_sy, rd_sz;
  norm_t                    rd_nx, rd_ny, rd_nz;

  // shared datapath
  logic signed [SUM_W-1:0]  sel_t, sel_p;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [DIST_W-1:0]        dist_term;
  logic [DIST_W-1:0]        dist_tot;
  logic signed [DOT_W-1:0]  dot_term;
  logic signed [DOT_W-1:0]  dot_tot;

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign is_query = in_acc && (in_ch.mode == MODE_QRY_NORMAL);
  assign last_ent = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));

  // -------------------------------------------------------------------------
  // table: {sum x, sum y, sum z, normal x, normal y, normal z}
  // -------------------------------------------------------------------------
  assign wr_en   = in_acc && (in_ch.mode == MODE_TGT_NORMAL) &&
                   (count_r < CNT_W'(MAX_ENTRIES));
  assign wr_data = {pend_x_r, pend_y_r, pend_z_r,
                    sat16(in_ch.vec_x), sat16(in_ch.vec_y), sat16(in_ch.vec_z)};

  ftnf_table #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ENTRY_W),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_sx = rd_data[ENTRY_W-1 -: SUM_W];
  assign rd_sy = rd_data[ENTRY_W-SUM_W-1 -: SUM_W];
  assign rd_sz = rd_data[ENTRY_W-2*SUM_W-1 -: SUM_W];
  assign rd_nx = rd_data[3*NORM_W-1 -: NORM_W];
  assign rd_ny = rd_data[2*NORM_W-1 -: NORM_W];
  assign rd_nz = rd_data[NORM_W-1:0];

  // -------------------------------------------------------------------------
  // sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_query) begin
          state_nxt = (count_r == '0) ? S_DONE : S_RD;
        end
      end
      S_RD:   state_nxt = S_SQX;
      S_SQX:  state_nxt = S_SQY;
      S_SQY:  state_nxt = S_SQZ;
      S_SQZ:  state_nxt = S_CMP;
      S_CMP:  state_nxt = last_ent ? S_NRD : S_SQX;
      S_NRD:  state_nxt = S_DX;
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_DZ;
      S_DZ:   state_nxt = S_DSUM;
      S_DSUM: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // sequencer: control outputs
  // -------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    unique case (state_r)
      S_IDLE: in_ch.ready = 1'b1;
      S_RD:   rd_en = 1'b1;
      S_SQZ: begin
        // prefetch the next entry; its data lands after the current squares
        rd_en   = ~last_ent;
        rd_addr = idx_r + IDX_W'(1);
      end
      S_NRD: begin
        rd_en   = 1'b1;
        rd_addr = best_idx_r;
      end
      S_DONE: out_load = ~out_valid_r | out_ch.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // shared subtractor and multiplier
  // -------------------------------------------------------------------------
  always_comb begin
    case (state_r)
      S_SQX: begin
        sel_t = rd_sx;
        sel_p = pend_x_r;
      end
      S_SQY: begin
        sel_t = rd_sy;
        sel_p = pend_y_r;
      end
      default: begin
        sel_t = rd_sz;
        sel_p = pend_z_r;
      end
    endcase
  end

  assign diff = DIFF_W'(sel_t) - DIFF_W'(sel_p);

  always_comb begin
    case (state_r)
      S_DX: begin
        mul_a = MUL_W'(qn_x_r);
        mul_b = MUL_W'(rd_nx);
      end
      S_DY: begin
        mul_a = MUL_W'(qn_y_r);
        mul_b = MUL_W'(rd_ny);
      end
      S_DZ: begin
        mul_a = MUL_W'(qn_z_r);
        mul_b = MUL_W'(rd_nz);
      end
      default: begin
        // squaring a centroid difference
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(diff);
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  // squares are never negative and fit the distance width
  assign dist_term = prod_r[DIST_W-1:0];
  assign dist_tot  = acc_r + dist_term;
  // a 16 by 16 bit product fits 32 bits
  assign dot_term  = DOT_W'(signed'(prod_r[2*NORM_W-1:0]));
  assign dot_tot   = dot_r + dot_term;

  // -------------------------------------------------------------------------
  // search and dot product registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      S_IDLE: begin
        if (is_query) begin
          idx_r   <= '0;
          qn_x_r  <= sat16(in_ch.vec_x);
          qn_y_r  <= sat16(in_ch.vec_y);
          qn_z_r  <= sat16(in_ch.vec_z);
          qidx_r  <= qcnt_r;
          empty_r <= (count_r == '0);
        end
      end
      S_SQY: acc_r <= dist_term;
      S_SQZ: acc_r <= dist_tot;
      S_CMP: begin
        // strict compare keeps the first of equal minima
        if ((idx_r == '0) || (dist_tot < best_r)) begin
          best_r     <= dist_tot;
          best_idx_r <= idx_r;
        end
        if (!last_ent) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      S_DY:   dot_r  <= dot_term;
      S_DZ:   dot_r  <= dot_tot;
      S_DSUM: keep_r <= (dot_tot < DOT_W'(thr_r));
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // fill count, pending sums, query counter, threshold
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pend_x_r <= '0;
      pend_y_r <= '0;
      pend_z_r <= '0;
      qcnt_r   <= '0;
      thr_r    <= THR_RESET;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (out_load) begin
        // the query used the pending sums; start afresh
        pend_x_r <= '0;
        pend_y_r <= '0;
        pend_z_r <= '0;
      end
      if (in_acc) begin
        unique case (in_ch.mode) inside
          MODE_TGT_CORNER, MODE_QRY_CORNER: begin
            pend_x_r <= pend_x_r + SUM_W'(in_ch.vec_x);
            pend_y_r <= pend_y_r + SUM_W'(in_ch.vec_y);
            pend_z_r <= pend_z_r + SUM_W'(in_ch.vec_z);
          end
          MODE_TGT_NORMAL: begin
            if (count_r < CNT_W'(MAX_ENTRIES)) begin
              count_r <= count_r + CNT_W'(1);
            end
            pend_x_r <= '0;
            pend_y_r <= '0;
            pend_z_r <= '0;
          end
          MODE_QRY_NORMAL: qcnt_r <= qcnt_r + QIDX_W'(1);
          MODE_CLEAR: begin
            count_r  <= '0;
            pend_x_r <= '0;
            pend_y_r <= '0;
            pend_z_r <= '0;
            qcnt_r   <= '0;
          end
          default: begin
            // unused codes are dropped
          end
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_keep_r  <= ~empty_r & keep_r;
      out_near_r  <= empty_r ? '0 : NEAR_W'(best_idx_r);
      out_qidx_r  <= qidx_r;
      out_empty_r <= empty_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.keep          = out_keep_r;
  assign out_ch.nearest_index = out_near_r;
  assign out_ch.query_index   = out_qidx_r;
  assign out_ch.no_entries    = out_empty_r;

endmodule

// File: src/ftnf_checker.sv
// port-level checks for the facing triangle nearest filter, bound to the top
// depends on ftnf_pkg and facing_triangle_nearest_filter_unit

module ftnf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ftnf_pkg::mode_t   in_mode,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_keep,
  input ftnf_pkg::near_t   out_nearest_index,
  input logic              out_no_entries
);
  import ftnf_pkg::*;

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a query word always makes the input side busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_QRY_NORMAL) |=> !in_ready)
    else $error("input ready right after a query word");

  // corner words never stall the input
  a_corner_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_mode == MODE_TGT_CORNER || in_mode == MODE_QRY_CORNER) |=> in_ready)
    else $error("input stalled after a corner word");

  // a new result only comes out of a search
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word appeared without a search");

  // an empty table gives neither keep nor an index
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_entries |-> !out_keep && (out_nearest_index == '0))
    else $error("empty-table result carries keep or index");

endmodule

bind facing_triangle_nearest_filter_unit ftnf_checker u_ftnf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_mode           (in_ch.mode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_keep          (out_ch.keep),
  .out_nearest_index (out_ch.nearest_index),
  .out_no_entries    (out_ch.no_entries)
);

// File: sim/ftnf_verdict_checker.sv
`timescale 1ns / 1ps
// scoreboard for the facing triangle nearest filter: keeps its own target table,
// predicts the verdict of every query word and compares it with the result channel
// depends on ftnf_pkg, ftnf_in_if and ftnf_out_if

module ftnf_verdict_checker
  import ftnf_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int SUM_W       = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  ftnf_in_if          in_ch,
  ftnf_out_if         out_ch,
  input  logic        cfg_we,
  input  thr_t        cfg_wdata,
  output int unsigned results_pending,
  output int unsigned mismatches
);

  localparam int REPORT_LIMIT = 10;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic  keep;
    near_t nearest_index;
    qidx_t query_index;
    logic  no_entries;
  } verdict_t;

  sum_t        tgt_sx [TABLE_DEPTH];
  sum_t        tgt_sy [TABLE_DEPTH];
  sum_t        tgt_sz [TABLE_DEPTH];
  norm_t       tgt_nx [TABLE_DEPTH];
  norm_t       tgt_ny [TABLE_DEPTH];
  norm_t       tgt_nz [TABLE_DEPTH];
  int unsigned tgt_count;
  sum_t        acc_x, acc_y, acc_z;
  qidx_t       query_seq;
  thr_t        threshold;
  verdict_t    verdicts_due [$];

  function automatic norm_t clamp_q14(input vec_t v);
    if (v > vec_t'(32767)) return 16'sh7fff;
    if (v < vec_t'(-32768)) return 16'sh8000;
    return norm_t'(v);
  endfunction

  // corner sums stand in for centroids scaled by three
  function automatic longint sq_dist(input int unsigned e);
    longint dx, dy, dz;
    dx = longint'(tgt_sx[e]) - longint'(acc_x);
    dy = longint'(tgt_sy[e]) - longint'(acc_y);
    dz = longint'(tgt_sz[e]) - longint'(acc_z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic verdict_t search_table(input norm_t nx, input norm_t ny, input norm_t nz);
    verdict_t    v;
    longint      best_d, d, dot;
    int unsigned best_e;
    v = '{keep: 1'b0, nearest_index: '0, query_index: query_seq, no_entries: 1'b1};
    if (tgt_count != 0) begin
      best_e = 0;
      best_d = sq_dist(0);
      // strict less: first minimum wins
      for (int unsigned e = 1; e < tgt_count; e++) begin
        d = sq_dist(e);
        if (d < best_d) begin
          best_d = d;
          best_e = e;
        end
      end
      dot = longint'(nx) * longint'(tgt_nx[best_e]) + longint'(ny) * longint'(tgt_ny[best_e])
          + longint'(nz) * longint'(tgt_nz[best_e]);
      v.keep          = (dot < longint'(threshold));
      v.nearest_index = near_t'(best_e);
      v.no_entries    = 1'b0;
    end
    return v;
  endfunction

  function automatic void drop_pending();
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
  endfunction

  task automatic take_word(input mode_t m, input vec_t x, input vec_t y, input vec_t z);
    case (m)
      MODE_TGT_CORNER, MODE_QRY_CORNER: begin
        acc_x = acc_x + sum_t'(x);
        acc_y = acc_y + sum_t'(y);
        acc_z = acc_z + sum_t'(z);
      end
      MODE_TGT_NORMAL: begin
        // full table: entry dropped, pending sums still cleared
        if (tgt_count < TABLE_DEPTH) begin
          tgt_sx[tgt_count] = acc_x;
          tgt_sy[tgt_count] = acc_y;
          tgt_sz[tgt_count] = acc_z;
          tgt_nx[tgt_count] = clamp_q14(x);
          tgt_ny[tgt_count] = clamp_q14(y);
          tgt_nz[tgt_count] = clamp_q14(z);
          tgt_count++;
        end
        drop_pending();
      end
      MODE_QRY_NORMAL: begin
        verdicts_due = {verdicts_due, search_table(clamp_q14(x), clamp_q14(y), clamp_q14(z))};
        query_seq = query_seq + 1'b1;
        drop_pending();
      end
      MODE_CLEAR: begin
        tgt_count = 0;
        query_seq = '0;
        drop_pending();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    verdict_t seen, want;
    if (!rst_n) begin
      tgt_count = 0;
      query_seq = '0;
      threshold = THR_RESET;
      drop_pending();
      verdicts_due.delete();
    end else begin
      if (cfg_we) threshold = cfg_wdata;
      // results first: a query word taken at this edge cannot already be answered
      if (out_ch.valid && out_ch.ready) begin
        seen = '{keep: out_ch.keep, nearest_index: out_ch.nearest_index,
                 query_index: out_ch.query_index, no_entries: out_ch.no_entries};
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result keep=%0b nearest=%0d query=%0d empty=%0b",
                     $time, seen.keep, seen.nearest_index, seen.query_index, seen.no_entries);
        end else begin
          want = verdicts_due.pop_front();
          if (seen.keep !== want.keep || seen.nearest_index !== want.nearest_index ||
              seen.query_index !== want.query_index || seen.no_entries !== want.no_entries) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: query %0d expected keep=%0b nearest=%0d query=%0d empty=%0b",
                       $time, want.query_index, want.keep, want.nearest_index,
                       want.query_index, want.no_entries,
                       ", got keep=%0b nearest=%0d query=%0d empty=%0b",
                       seen.keep, seen.nearest_index, seen.query_index, seen.no_entries);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        take_word(in_ch.mode, in_ch.vec_x, in_ch.vec_y, in_ch.vec_z);
    end
    results_pending = verdicts_due.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// top of the facing triangle nearest filter bench: clock, reset, stimulus and verdict
// depends on ftnf_pkg, both channel interfaces, the filter unit and ftnf_verdict_checker

module tb;
  import ftnf_pkg::*;

  localparam int TABLE_DEPTH      = 1024;
  // settling time that covers a query scan of a full table
  localparam int SETTLE_CYCLES    = 4 * TABLE_DEPTH + 16;
  localparam int HOLD_OFF_CYCLES  = 400;
  // random tables stay small so the scans stay short
  localparam int MAX_TABLE_RANDOM = 24;
  localparam int RUN_LIMIT_NS     = 2_000_000;

  localparam vec_t VEC_MAX = 24'sh7fffff;
  localparam vec_t VEC_MIN = 24'sh800000;
  localparam thr_t THR_MAX = 30'sd268435456;
  localparam thr_t THR_MIN = -30'sd268435456;

  // nine corner components, corner c at 3*c .. 3*c+2
  typedef logic [8:0][IN_W-1:0] tri_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  thr_t        cfg_wdata;
  int unsigned results_pending;
  int unsigned mismatches;

  // idle rates in percent, changed by phase
  int unsigned source_idle_pct;
  int unsigned sink_idle_pct;
  // raised once to make the result side hold off for a long stretch
  logic        hold_req;

  // what the stimulus knows of the table, for repeats and near misses
  int unsigned words_sent;
  int unsigned table_len;
  tri_t        tgt_tris [$];

  ftnf_in_if  in_ch ();
  ftnf_out_if out_ch ();

  facing_triangle_nearest_filter_unit #(
    .MAX_ENTRIES (TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ftnf_verdict_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) verdict_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .results_pending (results_pending),
    .mismatches      (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off counted here
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left     = 0;
    hold_done     = 1'b0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic vec_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return vec_t'($urandom);
    // a cluster round the origin so some distances are close
    if (pick < 90) return vec_t'($urandom_range(131072)) - 24'sd65536;
    case ($urandom_range(3))
      0:       return VEC_MAX;
      1:       return VEC_MIN;
      2:       return vec_t'(0);
      default: return vec_t'(-1);
    endcase
  endfunction

  function automatic vec_t rand_normal();
    int unsigned pick;
    pick = $urandom_range(99);
    // roughly unit components, so the dot product lands near the threshold range
    if (pick < 60) return vec_t'($urandom_range(32768)) - 24'sd16384;
    if (pick < 85) return vec_t'($urandom);
    // the saturation edges of the 16 bit normal
    case ($urandom_range(5))
      0:       return vec_t'(32767);
      1:       return vec_t'(-32768);
      2:       return vec_t'(32768);
      3:       return vec_t'(-32769);
      4:       return VEC_MAX;
      default: return VEC_MIN;
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    for (int i = 0; i < 9; i++) t[i] = rand_coord();
    return t;
  endfunction

  // offer one word, with random idle cycles in front, and hold it until taken
  task automatic put_word(input mode_t m, input vec_t x, input vec_t y, input vec_t z);
    @(negedge clk);
    while ($urandom_range(99) < source_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.vec_x <= x;
    in_ch.vec_y <= y;
    in_ch.vec_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // ignored codes do not count as stimulus
    if (m <= MODE_CLEAR) words_sent++;
    if (m == MODE_CLEAR) begin
      table_len = 0;
      tgt_tris.delete();
    end else if (m == MODE_TGT_NORMAL) begin
      table_len++;
    end
  endtask

  task automatic put_triangle(input mode_t corner_mode, input mode_t normal_mode, input tri_t t,
                              input vec_t nx, input vec_t ny, input vec_t nz);
    for (int c = 0; c < 3; c++) put_word(corner_mode, t[3*c], t[3*c+1], t[3*c+2]);
    put_word(normal_mode, nx, ny, nz);
  endtask

  // wait for every predicted result, then let the block settle before a register write
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input thr_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed targets and queries over small tables, with some noise
  task automatic random_traffic(input int unsigned n_words);
    int unsigned stop_at, pick, n_corners;
    tri_t        t;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // stray word of any code, the unused ones among them
        put_word(mode_t'($urandom_range(7)), vec_t'($urandom), vec_t'($urandom),
                 vec_t'($urandom));
      end else if (pick < 9) begin
        put_word(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 14) begin
        // broken triangle: zero to five corners of either kind, then either normal
        n_corners = $urandom_range(5);
        repeat (n_corners)
          put_word($urandom_range(1) ? MODE_TGT_CORNER : MODE_QRY_CORNER,
                   rand_coord(), rand_coord(), rand_coord());
        put_word($urandom_range(1) ? MODE_TGT_NORMAL : MODE_QRY_NORMAL,
                 rand_normal(), rand_normal(), rand_normal());
      end else if (pick < 50 || tgt_tris.size() == 0) begin
        if (table_len >= MAX_TABLE_RANDOM)
          put_word(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord());
        // repeated targets give distance ties
        if (tgt_tris.size() != 0 && $urandom_range(99) < 15)
          t = tgt_tris[$urandom_range(tgt_tris.size() - 1)];
        else
          t = rand_tri();
        put_triangle(MODE_TGT_CORNER, MODE_TGT_NORMAL, t, rand_normal(), rand_normal(),
                     rand_normal());
        tgt_tris = {tgt_tris, t};
      end else begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          t = tgt_tris[$urandom_range(tgt_tris.size() - 1)];
        end else if (pick < 40) begin
          t = tgt_tris[$urandom_range(tgt_tris.size() - 1)];
          for (int i = 0; i < 9; i++) t[i] = t[i] + IN_W'($urandom_range(6)) - IN_W'(3);
        end else begin
          t = rand_tri();
        end
        // the corner accumulator is shared, so query corners may come as target corners
        put_triangle(($urandom_range(99) < 85) ? MODE_QRY_CORNER : MODE_TGT_CORNER,
                     MODE_QRY_NORMAL, t, rand_normal(), rand_normal(), rand_normal());
      end
    end
  endtask

  initial begin : stimulus
    tri_t t;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_CLEAR;
    in_ch.vec_x     = '0;
    in_ch.vec_y     = '0;
    in_ch.vec_z     = '0;
    hold_req        = 1'b0;
    words_sent      = 0;
    table_len       = 0;
    source_idle_pct = 19;
    sink_idle_pct   = 53;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, threshold still at its reset value
    put_word(MODE_CLEAR, '0, '0, '0);
    // query against an empty table
    put_word(MODE_QRY_CORNER, VEC_MAX, VEC_MIN, '0);
    put_word(MODE_QRY_NORMAL, VEC_MAX, VEC_MAX, VEC_MIN);
    // unused codes give nothing
    for (int k = 1; k <= 3; k++) put_word(MODE_CLEAR + mode_t'(k), VEC_MAX, VEC_MIN, VEC_MAX);
    // entry 0: five corners at the minimum wrap the 26 bit sum, normal saturates
    repeat (5) put_word(MODE_TGT_CORNER, VEC_MIN, VEC_MIN, VEC_MIN);
    put_word(MODE_TGT_NORMAL, VEC_MAX, VEC_MIN, 24'sd32768);
    // entry 1: no corners at all, sum stays zero
    put_word(MODE_TGT_NORMAL, -24'sd1638, 24'sd1, 24'sd0);
    // entry 2: sum (2,0,0)
    put_word(MODE_TGT_CORNER, 24'sd2, 24'sd0, 24'sd0);
    put_word(MODE_TGT_NORMAL, -24'sd1638, 24'sd2, 24'sd0);
    // nearest entry 2, dot below the threshold: kept
    put_word(MODE_QRY_CORNER, 24'sd2, 24'sd0, 24'sd0);
    put_word(MODE_QRY_NORMAL, 24'sd16384, -24'sd6554, 24'sd0);
    // tie between entries 1 and 2 goes to 1, dot equal to the threshold: not kept
    put_word(MODE_QRY_CORNER, 24'sd1, 24'sd0, 24'sd0);
    put_word(MODE_QRY_NORMAL, 24'sd16384, -24'sd6554, 24'sd0);
    // exact hit on entry 0 built from target corner words, saturated normals
    repeat (5) put_word(MODE_TGT_CORNER, VEC_MIN, VEC_MIN, VEC_MIN);
    put_word(MODE_QRY_NORMAL, VEC_MIN, VEC_MAX, -24'sd32769);

    // random phase, sender idling lightly, result side heavily
    drain();
    set_threshold(THR_MAX);
    random_traffic(190);

    // random phase with the idle rates swapped
    drain();
    source_idle_pct = 53;
    sink_idle_pct   = 19;
    set_threshold(THR_MIN);
    random_traffic(190);

    // no idling; long result hold-off while queries keep coming, so the input stalls
    drain();
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    set_threshold('0);
    put_word(MODE_CLEAR, '0, '0, '0);
    repeat (3) begin
      t = rand_tri();
      put_triangle(MODE_TGT_CORNER, MODE_TGT_NORMAL, t, rand_normal(), rand_normal(),
                   rand_normal());
      tgt_tris = {tgt_tris, t};
    end
    hold_req = 1'b1;
    repeat (16)
      put_triangle(MODE_QRY_CORNER, MODE_QRY_NORMAL, rand_tri(), rand_normal(),
                   rand_normal(), rand_normal());
    random_traffic(110);

    drain();
    if (mismatches == 0 && results_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
